### rtl/kth_largest_stream_tracker_unit_defines.svh
// Shared assertion macros for the tracker checker.
`ifndef KTH_LARGEST_STREAM_TRACKER_UNIT_DEFINES_SVH
`define KTH_LARGEST_STREAM_TRACKER_UNIT_DEFINES_SVH

// Clocked implication, quiet while reset is asserted.
`define KTHTRK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define KTHTRK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/kthtrk_pkg.sv
package kthtrk_pkg;

	localparam int unsigned K_MAX  = 16;
	localparam int unsigned CNT_W  = $clog2(K_MAX + 1);
	localparam int unsigned RANK_W = 5;
	localparam int unsigned VAL_W  = 32;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [RANK_W-1:0]       rank_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	typedef struct packed {
		logic insert;
		logic clear;
	} dp_cmd_t;

	// Rank zero reads as one, ranks above the row length saturate.
	function automatic cnt_t eff_k(input rank_t r);
		cnt_t k;
		if (r == '0) begin
			k = cnt_t'(1);
		end else if (int'(r) > int'(K_MAX)) begin
			k = cnt_t'(K_MAX);
		end else begin
			k = cnt_t'(r);
		end
		return k;
	endfunction

endpackage

### rtl/kthtrk_ctrl.sv
module kthtrk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_we,
	output kthtrk_pkg::dp_cmd_t cmd
);
	import kthtrk_pkg::*;

	state_t state_q;
	state_t state_d;

	// hold off the sample beat while a rank write empties the store
	assign in_ready   = (state_q == S_IDLE) && !cfg_we;
	assign out_valid  = (state_q == S_HOLD);
	assign cmd.clear  = cfg_we;
	assign cmd.insert = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.insert) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/kthtrk_row.sv
module kthtrk_row (
	input  logic                clk,
	input  logic                arst_n,
	input  kthtrk_pkg::dp_cmd_t cmd,
	input  kthtrk_pkg::rank_t   cfg_wdata,
	input  kthtrk_pkg::val_t    sample_value,
	output kthtrk_pkg::val_t    kth_value,
	output logic                store_full
);
	import kthtrk_pkg::*;

	val_t  cell_q [K_MAX];
	val_t  nxt    [K_MAX];
	logic  valid  [K_MAX];
	logic  le     [K_MAX];
	logic  lt     [K_MAX];
	cnt_t  count_q;
	cnt_t  count_d;
	rank_t rank_q;
	cnt_t  k_eff;
	logic  grow;
	logic  hit;
	val_t  kth_q;
	logic  full_q;

	assign k_eff = eff_k(rank_q);
	assign grow  = (count_q < k_eff);
	assign hit   = lt[0];

	always_comb begin
		for (int i = 0; i < int'(K_MAX); i++) begin
			valid[i] = (cnt_t'(i) < count_q);
			le[i]    = valid[i] && (cell_q[i] <= sample_value);
			lt[i]    = valid[i] && (cell_q[i] < sample_value);
		end
	end

	// Each cell picks its next value from itself, a neighbor or the new sample.
	always_comb begin
		for (int i = 0; i < int'(K_MAX); i++) begin
			nxt[i] = cell_q[i];
			if (grow) begin
				if (le[i]) begin
					nxt[i] = cell_q[i];
				end else if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
					nxt[i] = sample_value;
				end else if (cnt_t'(i) <= count_q) begin
					nxt[i] = cell_q[(i == 0) ? 0 : i - 1];
				end
			end else if (hit) begin
				// drop the head, slide larger entries down until the sample fits
				if (cnt_t'(i + 1) < k_eff && lt[(i == int'(K_MAX) - 1) ? i : i + 1]) begin
					nxt[i] = cell_q[(i == int'(K_MAX) - 1) ? i : i + 1];
				end else if (lt[i]) begin
					nxt[i] = sample_value;
				end
			end
		end
	end

	assign count_d = grow ? count_q + cnt_t'(1) : count_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < int'(K_MAX); i++) begin
				cell_q[i] <= nxt[i];
			end
			kth_q <= nxt[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rank_q  <= rank_t'(1);
			full_q  <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			rank_q  <= cfg_wdata;
		end else if (cmd.insert) begin
			count_q <= count_d;
			full_q  <= (count_d >= k_eff);
		end
	end

	assign kth_value  = kth_q;
	assign store_full = full_q;

endmodule

### rtl/kth_largest_stream_tracker_unit.sv
// Streaming k-th largest tracker. Each sample beat is inserted into a sorted
// row of K_MAX compare cells in the cycle it is accepted; the result beat
// (smallest retained value, and store_full once rank_k samples are held)
// appears on the next cycle and is held until taken. One item is in flight at
// a time: a new sample is not accepted while a result beat waits. Each sample
// is first inserted into the cell row, then the output register hands over the
// beat. Writing cfg_wdata sets rank_k (0 acts as 1, above K_MAX acts as
// K_MAX) and empties the store; no clearing pass is needed after reset.
module kth_largest_stream_tracker_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kthtrk_pkg::val_t  sample_value,
	output logic              out_valid,
	input  logic              out_ready,
	output kthtrk_pkg::val_t  kth_value,
	output logic              store_full,
	input  logic              cfg_we,
	input  kthtrk_pkg::rank_t cfg_wdata
);
	import kthtrk_pkg::*;

	dp_cmd_t cmd;

	kthtrk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cmd       (cmd)
	);

	kthtrk_row u_row (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wdata    (cfg_wdata),
		.sample_value (sample_value),
		.kth_value    (kth_value),
		.store_full   (store_full)
	);

endmodule

### rtl/kthtrk_chk.sv
`include "kth_largest_stream_tracker_unit_defines.svh"

module kthtrk_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input kthtrk_pkg::val_t  sample_value,
	input logic              out_valid,
	input logic              out_ready,
	input kthtrk_pkg::val_t  kth_value,
	input logic              store_full,
	input logic              cfg_we,
	input kthtrk_pkg::rank_t cfg_wdata
);
	import kthtrk_pkg::*;

	`KTHTRK_ASSERT(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(kth_value) && $stable(store_full),
		"stalled result beat changed")

	`KTHTRK_ASSERT(a_result_follows,
		in_valid && in_ready && !cfg_we |=> out_valid,
		"accepted sample gave no result beat")

	`KTHTRK_ASSERT(a_one_in_flight,
		!(out_valid && in_ready),
		"new sample taken while a result waits")

	`KTHTRK_ASSERT(a_rank_one_full,
		in_valid && in_ready && !cfg_we && $past(cfg_we) && $past(cfg_wdata) <= 1 |=> store_full,
		"first sample after rank one write not reported full")

endmodule

bind kth_largest_stream_tracker_unit kthtrk_chk u_kthtrk_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.sample_value (sample_value),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kth_value    (kth_value),
	.store_full   (store_full),
	.cfg_we       (cfg_we),
	.cfg_wdata    (cfg_wdata)
);
